@@ hdl/kq_pkg.sv @@
// ----------------------------------------------------------------------------
// kq_pkg
// Shared constants, codes and control types for the segmented queue block.
// ----------------------------------------------------------------------------
package kq_pkg;

    // Storage size; must be a power of two so address wrap is a bit select
    localparam int MEM_DEPTH  = 128;
    localparam int MAX_QUEUES = 8;

    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int QSEL_W     = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int QIDX_W     = 3;
    localparam int QCOUNT_W   = 4;
    localparam int SEG_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Width of segment base plus offset before the wrap
    localparam int SUM_W      = QIDX_W + SEG_W + 1;
    // Width used to compare the queue index against the active count
    localparam int CMP_W      = 8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // Action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = 2'd1;

    // Configuration reset values
    localparam logic [QCOUNT_W-1:0] QCOUNT_RESET = 4'd4;
    localparam logic [SEG_W-1:0]    SEG_RESET    = 8'd32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;    // capture the accepted input beat
        logic exec;         // decide, touch storage, update pointers
        logic finish_read;  // move storage read data into the output slot
        logic cfg_write;    // configuration beat accepted
    } kq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_read;    // current item is a dequeue that succeeds
        logic out_free;     // output slot can take a result this cycle
    } kq_stat_t;

endpackage

@@ hdl/kq_ctrl.sv @@
// ----------------------------------------------------------------------------
// kq_ctrl
// Sequencer: accepts one item, runs it through the datapath, waits for the
// storage read on a successful dequeue and for room in the output slot.
// ----------------------------------------------------------------------------
module kq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cfg_valid,
    output logic              in_ready,
    output logic              cfg_ready,
    output kq_pkg::kq_cmd_t   cmd,
    input  kq_pkg::kq_stat_t  stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Handshake readiness: configuration takes precedence in idle
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd.load_item   = 1'b0;
        cmd.exec        = 1'b0;
        cmd.finish_read = 1'b0;
        cmd.cfg_write   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.cfg_write = cfg_valid;
                cmd.load_item = in_valid && !cfg_valid;
                if (in_valid && !cfg_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // a read needs no output room yet; anything else loads the slot now
                if (stat.need_read || stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.need_read ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.finish_read = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // Read wait is only reached through execute
    a_read_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |->
            ($past(state_reg) == S_EXEC || $past(state_reg) == S_READ))
        else $error("read wait entered without execute");

    // Each item executes once
    a_single_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec)
        else $error("execute issued on consecutive cycles");
`endif

endmodule

@@ hdl/kq_dp.sv @@
// ----------------------------------------------------------------------------
// kq_dp
// Datapath: configuration registers, per-queue head/tail/occupancy, the
// shared storage memory and the output register.
// ----------------------------------------------------------------------------
module kq_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  kq_pkg::kq_cmd_t                        cmd,
    output kq_pkg::kq_stat_t                       stat,
    input  logic                                   action,
    input  logic [kq_pkg::QIDX_W-1:0]              queue_index,
    input  logic signed [kq_pkg::DATA_W-1:0]       value,
    input  logic [kq_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [kq_pkg::CFG_DATA_W-1:0]          cfg_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [kq_pkg::STATUS_W-1:0]            status,
    output logic signed [kq_pkg::DATA_W-1:0]       data_out
);

    // Step an offset inside its segment, wrapping to the segment start
    function automatic logic [kq_pkg::SEG_W-1:0] kq_advance(
        input logic [kq_pkg::SEG_W-1:0] off,
        input logic [kq_pkg::SEG_W-1:0] seg
    );
        logic [kq_pkg::SEG_W:0] nxt;
        nxt = {1'b0, off} + {{kq_pkg::SEG_W{1'b0}}, 1'b1};
        return (nxt >= {1'b0, seg}) ? '0 : nxt[kq_pkg::SEG_W-1:0];
    endfunction

    // Configuration
    logic [kq_pkg::QCOUNT_W-1:0] qcount_reg;
    logic [kq_pkg::SEG_W-1:0]    seg_reg;
    logic                        flush;

    // Captured item
    logic                        action_reg;
    logic [kq_pkg::QIDX_W-1:0]   item_q_reg;
    logic [kq_pkg::DATA_W-1:0]   value_reg;

    // Per-queue pointers
    logic [kq_pkg::SEG_W-1:0] head_reg [kq_pkg::MAX_QUEUES];
    logic [kq_pkg::SEG_W-1:0] tail_reg [kq_pkg::MAX_QUEUES];
    logic [kq_pkg::SEG_W-1:0] occ_reg  [kq_pkg::MAX_QUEUES];
    logic [kq_pkg::SEG_W-1:0] head_next [kq_pkg::MAX_QUEUES];
    logic [kq_pkg::SEG_W-1:0] tail_next [kq_pkg::MAX_QUEUES];
    logic [kq_pkg::SEG_W-1:0] occ_next  [kq_pkg::MAX_QUEUES];

    // Storage
    logic [kq_pkg::DATA_W-1:0] storage_reg [kq_pkg::MEM_DEPTH];
    logic [kq_pkg::DATA_W-1:0] rd_data_reg;

    // Output slot
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [kq_pkg::STATUS_W-1:0] status_reg;
    logic [kq_pkg::DATA_W-1:0]   data_out_reg;

    // Decode
    logic [kq_pkg::QSEL_W+kq_pkg::QIDX_W-1:0] q_wide;
    logic [kq_pkg::QSEL_W-1:0]   qsel;
    logic                        bad_index;
    logic [kq_pkg::SEG_W-1:0]    head_cur;
    logic [kq_pkg::SEG_W-1:0]    tail_cur;
    logic [kq_pkg::SEG_W-1:0]    occ_cur;
    logic [kq_pkg::SEG_W-1:0]    off_sel;
    logic [kq_pkg::SUM_W-1:0]    base;
    logic [kq_pkg::SUM_W-1:0]    addr_sum;
    logic [kq_pkg::ADDR_W-1:0]   addr;
    logic                        full;
    logic                        empty;
    logic                        enq_ok;
    logic                        deq_ok;
    logic [kq_pkg::STATUS_W-1:0] status_exec;
    logic                        load_out;

    assign flush = cmd.cfg_write &&
        (cfg_index == kq_pkg::CFG_QUEUE_COUNT || cfg_index == kq_pkg::CFG_SEGMENT_LENGTH);

    // Select the addressed queue and check it is active
    assign q_wide    = {{kq_pkg::QSEL_W{1'b0}}, item_q_reg};
    assign qsel      = q_wide[kq_pkg::QSEL_W-1:0];
    assign bad_index = (kq_pkg::CMP_W'(item_q_reg) >= kq_pkg::CMP_W'(qcount_reg)) ||
                       (kq_pkg::CMP_W'(item_q_reg) >= kq_pkg::CMP_W'(kq_pkg::MAX_QUEUES));

    assign head_cur = head_reg[qsel];
    assign tail_cur = tail_reg[qsel];
    assign occ_cur  = occ_reg[qsel];

    // Storage address: segment base plus offset, wrapped to the memory depth
    assign off_sel  = (action_reg == kq_pkg::ACT_ENQ) ? tail_cur : head_cur;
    assign base     = kq_pkg::SUM_W'(item_q_reg) * kq_pkg::SUM_W'(seg_reg);
    assign addr_sum = base + kq_pkg::SUM_W'(off_sel);
    assign addr     = addr_sum[kq_pkg::ADDR_W-1:0];

    // Outcome of the item
    assign full   = (occ_cur >= seg_reg);
    assign empty  = (occ_cur == '0) || (seg_reg == '0);
    assign enq_ok = !bad_index && (action_reg == kq_pkg::ACT_ENQ) && !full;
    assign deq_ok = !bad_index && (action_reg == kq_pkg::ACT_DEQ) && !empty;

    always_comb
    begin
        if (bad_index)
        begin
            status_exec = kq_pkg::ST_BAD_INDEX;
        end
        else if (action_reg == kq_pkg::ACT_ENQ)
        begin
            status_exec = full ? kq_pkg::ST_FULL : kq_pkg::ST_OK;
        end
        else
        begin
            status_exec = empty ? kq_pkg::ST_EMPTY : kq_pkg::ST_OK;
        end
    end

    assign stat.need_read = deq_ok;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg <= kq_pkg::QCOUNT_RESET;
            seg_reg    <= kq_pkg::SEG_RESET;
        end
        else if (cmd.cfg_write)
        begin
            if (cfg_index == kq_pkg::CFG_QUEUE_COUNT)
            begin
                qcount_reg <= cfg_data[kq_pkg::QCOUNT_W-1:0];
            end
            if (cfg_index == kq_pkg::CFG_SEGMENT_LENGTH)
            begin
                seg_reg <= cfg_data[kq_pkg::SEG_W-1:0];
            end
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action;
            item_q_reg <= queue_index;
            value_reg  <= $unsigned(value);
        end
    end

    // Advance pointers of the addressed queue
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (cmd.exec && enq_ok)
        begin
            tail_next[qsel] = kq_advance(tail_cur, seg_reg);
            occ_next[qsel]  = occ_cur + kq_pkg::SEG_W'(1);
        end
        else if (cmd.exec && deq_ok)
        begin
            head_next[qsel] = kq_advance(head_cur, seg_reg);
            occ_next[qsel]  = occ_cur - kq_pkg::SEG_W'(1);
        end
    end

    // Pointer registers; a write to either configuration register flushes every queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kq_pkg::MAX_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
        end
        else if (flush)
        begin
            for (int i = 0; i < kq_pkg::MAX_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    // Shared storage: at most one write or one registered read per item
    always_ff @(posedge clk)
    begin
        if (cmd.exec && enq_ok)
        begin
            storage_reg[addr] <= value_reg;
        end
        if (cmd.exec && deq_ok)
        begin
            rd_data_reg <= storage_reg[addr];
        end
    end

    // Output slot: load a result, drop it when the beat is taken
    assign load_out = (cmd.exec && !deq_ok) || cmd.finish_read;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_read)
        begin
            status_reg   <= kq_pkg::ST_OK;
            data_out_reg <= rd_data_reg;
        end
        else if (load_out)
        begin
            status_reg   <= status_exec;
            data_out_reg <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = $signed(data_out_reg);

`ifndef SYNTHESIS
    // Occupancy of queue zero never exceeds the segment length
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg[0] <= seg_reg)
        else $error("queue occupancy above segment length");

    // Head offset of queue zero stays inside its segment
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg[0] < seg_reg) || (seg_reg == '0))
        else $error("head offset outside segment");

    // A new result appears only when the controller loads one
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(load_out))
        else $error("output valid rose without a load");
`endif

endmodule

@@ hdl/k_queues_in_one_array.sv @@
// ----------------------------------------------------------------------------
// k_queues_in_one_array
// Several circular queues sharing one storage memory in equal segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_ready): action 0 enqueues value to queue_index,
//   action 1 dequeues from it. Each beat yields one output beat
//   (out_valid/out_ready) with status (ok, full, empty, bad index) and
//   data_out, which holds the dequeued word on an ok dequeue and zero otherwise.
//   Config beat (cfg_valid/cfg_ready): index 0 sets queue_count, index 1 sets
//   segment_length; either write empties all queues, other indexes are ignored.
//   Items are handled one at a time. An enqueue or a failed access is captured
//   and then executed straight into the output register; an ok dequeue is
//   captured, executed with a registered storage read, and then moved into the
//   output register. The next item is accepted only after the result of the
//   last one has been loaded into the output register.
//   Reset empties all queues and loads queue_count 4, segment_length 32;
//   storage contents are not cleared. If the receiver stalls, the result holds
//   in the output register and the block waits before loading the next result.
// ----------------------------------------------------------------------------
module k_queues_in_one_array (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [kq_pkg::QIDX_W-1:0]           queue_index,
    input  logic signed [kq_pkg::DATA_W-1:0]    value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kq_pkg::STATUS_W-1:0]         status,
    output logic signed [kq_pkg::DATA_W-1:0]    data_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kq_pkg::CFG_DATA_W-1:0]       cfg_data
);

    kq_pkg::kq_cmd_t  cmd;
    kq_pkg::kq_stat_t stat;

    // Sequencer
    kq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .in_ready  (in_ready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Queue state, storage and output register
    kq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .queue_index (queue_index),
        .value       (value),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data_out    (data_out)
    );

endmodule

@@ bench/queue_checker.sv @@
// ----------------------------------------------------------------------------
// queue_checker
// Watches the input, result and register channels of the shared-memory queue
// block. Keeps its own copy of the segments, pointers and fill levels, works
// out the status and data for every accepted access and compares each result
// beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module queue_checker
    import kq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        action,
    input  logic [QIDX_W-1:0]           queue_index,
    input  logic signed [DATA_W-1:0]    value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [STATUS_W-1:0]         status,
    input  logic signed [DATA_W-1:0]    data_out,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          fail_count,
    output int                          outstanding,
    output int                          access_count,
    output int                          reg_write_count,
    output int                          ok_count,
    output int                          full_count,
    output int                          empty_count,
    output int                          bad_index_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
    } access_result_t;

    // Mirror of the block's storage and per-queue bookkeeping
    logic [DATA_W-1:0]   words    [MEM_DEPTH];
    logic [SEG_W-1:0]    head_off [MAX_QUEUES];
    logic [SEG_W-1:0]    tail_off [MAX_QUEUES];
    logic [SEG_W-1:0]    fill     [MAX_QUEUES];
    logic [QCOUNT_W-1:0] queue_count;
    logic [SEG_W-1:0]    seg_len;

    access_result_t      due_results [$];

    // Empty every queue; storage words survive
    function automatic void empty_queues();
        for (int i = 0; i < MAX_QUEUES; i++)
        begin
            head_off[i] = '0;
            tail_off[i] = '0;
            fill[i]     = '0;
        end
    endfunction

    // Advance an offset, wrapping to the start of its own segment
    function automatic logic [SEG_W-1:0] step_offset(logic [SEG_W-1:0] off);
        if (int'(off) + 1 >= int'(seg_len))
            return SEG_W'(0);
        return off + 1'b1;
    endfunction

    // Apply one access to the mirror and return the result it must produce
    function automatic access_result_t apply_access(logic act, logic [QIDX_W-1:0] q,
                                                    logic [DATA_W-1:0] v);
        access_result_t r;
        int             active;
        int             addr;
        r.status = ST_OK;
        r.data   = '0;
        active   = (int'(queue_count) > MAX_QUEUES) ? MAX_QUEUES : int'(queue_count);
        if (int'(q) >= active)
        begin
            r.status = ST_BAD_INDEX;
        end
        else if (act == ACT_ENQ)
        begin
            if (fill[q] >= seg_len)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                addr        = (int'(q) * int'(seg_len) + int'(tail_off[q])) % MEM_DEPTH;
                words[addr] = v;
                tail_off[q] = step_offset(tail_off[q]);
                fill[q]     = fill[q] + 1'b1;
            end
        end
        else
        begin
            if (fill[q] == 0 || seg_len == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                addr        = (int'(q) * int'(seg_len) + int'(head_off[q])) % MEM_DEPTH;
                r.data      = words[addr];
                head_off[q] = step_offset(head_off[q]);
                fill[q]     = fill[q] - 1'b1;
            end
        end
        return r;
    endfunction

    // Track every beat on the three channels
    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;
        if (!rst_n)
        begin
            queue_count = QCOUNT_RESET;
            seg_len     = SEG_RESET;
            empty_queues();
            due_results.delete();
            outstanding = 0;
        end
        else
        begin
            // compare a result beat with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing due: status %0d data_out %h",
                           status, data_out);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (data_out !== want.data)
                    begin
                        $error("data_out: expected %h, got %h", want.data, data_out);
                        fail_count++;
                    end
                    case (want.status)
                        ST_OK:    ok_count++;
                        ST_FULL:  full_count++;
                        ST_EMPTY: empty_count++;
                        default:  bad_index_count++;
                    endcase
                end
            end

            // register beat: either real register flushes all queues
            if (cfg_valid && cfg_ready)
            begin
                reg_write_count++;
                case (cfg_index)
                    CFG_QUEUE_COUNT:
                    begin
                        queue_count = cfg_data[QCOUNT_W-1:0];
                        empty_queues();
                    end
                    CFG_SEGMENT_LENGTH:
                    begin
                        seg_len = cfg_data;
                        empty_queues();
                    end
                    default: ;
                endcase
            end

            // access beat: predict and hold the result
            if (in_valid && in_ready)
            begin
                access_count++;
                due_results.push_back(apply_access(action, queue_index, value));
            end
            outstanding = due_results.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Regression for the shared-memory queue block. A directed opening hits the
// extreme data words, full, empty and inactive queues and pointer wrap, then
// randomized phases sweep queue counts and segment lengths (zero, overlapping
// and full-memory layouts) under bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kq_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 250;
    localparam int CYCLE_LIMIT   = 400000;

    // Register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {SINK_FREE, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       action;
    logic [QIDX_W-1:0]          queue_index;
    logic signed [DATA_W-1:0]   value;
    logic                       out_valid;
    logic                       out_ready;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   data_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int                         fail_count;
    int                         outstanding;
    int                         access_count;
    int                         reg_write_count;
    int                         ok_count;
    int                         full_count;
    int                         empty_count;
    int                         bad_index_count;
    int                         hold_requests;

    k_queues_in_one_array uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .queue_index (queue_index),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .data_out    (data_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    queue_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .queue_index     (queue_index),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .data_out        (data_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .access_count    (access_count),
        .reg_write_count (reg_write_count),
        .ok_count        (ok_count),
        .full_count      (full_count),
        .empty_count     (empty_count),
        .bad_index_count (bad_index_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offer one access beat and hold it until accepted
    task automatic push_item(input logic act, input logic [QIDX_W-1:0] q,
                             input logic [DATA_W-1:0] v);
        in_valid    <= 1'b1;
        action      <= act;
        queue_index <= q;
        value       <= v;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    // Drop valid for a gap between bursts
    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait for every predicted result to arrive
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Send one register beat; valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
    endtask

    // Program both registers in random order if asked, optionally poke an unused index
    task automatic program_regs(input logic [QCOUNT_W-1:0] qc, input logic [SEG_W-1:0] seg,
                                input bit touch_regs, input bit add_spare);
        logic [CFG_DATA_W-1:0] qc_byte;
        qc_byte = {4'($urandom), qc};
        if (touch_regs)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_QUEUE_COUNT, qc_byte);
                write_reg(CFG_SEGMENT_LENGTH, seg);
            end
            else
            begin
                write_reg(CFG_SEGMENT_LENGTH, seg);
                write_reg(CFG_QUEUE_COUNT, qc_byte);
            end
        end
        if (add_spare)
            write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // One randomized phase: reprogram when idle, then a stream of accesses
    task automatic run_phase(input logic [QCOUNT_W-1:0] qc, input logic [SEG_W-1:0] seg,
                             input int items, input int enq_pct, input bit touch_regs,
                             input bit long_hold, input bit mid_drain);
        int                 active;
        int                 burst_left;
        bit                 gappy;
        logic               act;
        logic [QIDX_W-1:0]  q;
        logic [DATA_W-1:0]  v;
        wait_drained(SETTLE_CYCLES);
        program_regs(qc, seg, touch_regs, $urandom_range(0, 1) == 1);
        active = (int'(qc) > MAX_QUEUES) ? MAX_QUEUES : int'(qc);
        if (long_hold)
            hold_requests <= hold_requests + 1;
        gappy      = $urandom_range(0, 3) != 0;
        burst_left = $urandom_range(1, 16);
        for (int n = 0; n < items; n++)
        begin
            // pause once until the block has emptied, or idle between bursts
            if (mid_drain && n == items / 2)
            begin
                wait_drained(0);
            end
            else if (gappy && burst_left == 0)
            begin
                idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
            if (active > 0 && $urandom_range(0, 99) < 85)
                q = QIDX_W'($urandom_range(0, active - 1));
            else
                q = QIDX_W'($urandom_range(0, MAX_QUEUES - 1));
            case ($urandom_range(0, 15))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h0000_0000;
                3:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            push_item(act, q, v);
        end
    endtask

    // Result sink: shifting stall patterns plus requested long hold-offs
    initial
    begin
        int         holds_done;
        int         left;
        sink_mode_t mode;
        logic [7:0] mask;
        holds_done = 0;
        left       = 0;
        mode       = SINK_FREE;
        mask       = '1;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 96);
                    mask = 8'($urandom);
                end
                left--;
                case (mode)
                    SINK_FREE:    out_ready <= 1'b1;
                    SINK_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                    SINK_PATTERN:
                    begin
                        out_ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Run limit
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results still due", cycles, outstanding);
        $display("k_queues_in_one_array regression: fail");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        action        <= ACT_ENQ;
        queue_index   <= '0;
        value         <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_QUEUE_COUNT;
        cfg_data      <= '0;
        hold_requests <= 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset layout: extreme words through queue zero, then drain it dry
        push_item(ACT_ENQ, 3'd0, 32'h8000_0000);
        push_item(ACT_ENQ, 3'd0, 32'h7FFF_FFFF);
        push_item(ACT_ENQ, 3'd0, 32'h0000_0000);
        push_item(ACT_ENQ, 3'd0, 32'hFFFF_FFFF);
        repeat (4) push_item(ACT_DEQ, 3'd0, 32'hFFFF_FFFF);
        push_item(ACT_DEQ, 3'd0, 32'h0000_0000);
        // last active queue, inactive indexes, untouched queue
        push_item(ACT_ENQ, 3'd3, 32'h1234_5678);
        push_item(ACT_DEQ, 3'd3, 32'h0000_0000);
        push_item(ACT_ENQ, 3'd4, 32'hA5A5_A5A5);
        push_item(ACT_DEQ, 3'd7, 32'h0000_0000);
        push_item(ACT_DEQ, 3'd1, 32'h0000_0000);

        // Two-entry segments: fill, overflow, wrap and underflow queue seven
        wait_drained(SETTLE_CYCLES);
        program_regs(4'd8, 8'd2, 1'b1, 1'b0);
        push_item(ACT_ENQ, 3'd7, 32'h0000_0011);
        push_item(ACT_ENQ, 3'd7, 32'h0000_0022);
        push_item(ACT_ENQ, 3'd7, 32'h0000_0033);
        push_item(ACT_DEQ, 3'd7, 32'h0000_0000);
        push_item(ACT_ENQ, 3'd7, 32'h0000_0044);
        push_item(ACT_DEQ, 3'd7, 32'h0000_0000);
        push_item(ACT_DEQ, 3'd7, 32'h0000_0000);
        push_item(ACT_DEQ, 3'd7, 32'h0000_0000);

        // Zero-length segments, then no active queues
        wait_drained(SETTLE_CYCLES);
        program_regs(4'd8, 8'd0, 1'b1, 1'b0);
        push_item(ACT_ENQ, 3'd0, 32'hDEAD_BEEF);
        push_item(ACT_DEQ, 3'd0, 32'h0000_0000);
        wait_drained(SETTLE_CYCLES);
        program_regs(4'd0, 8'd0, 1'b1, 1'b0);
        push_item(ACT_ENQ, 3'd0, 32'hCAFE_F00D);

        // Randomized sweep across layouts
        run_phase(4'd1,  8'd1,   60,  50, 1'b1, 1'b0, 1'b0);
        run_phase(4'd8,  8'd16,  120, 60, 1'b1, 1'b0, 1'b1);
        run_phase(4'd15, 8'd3,   100, 50, 1'b1, 1'b0, 1'b0);
        run_phase(4'd2,  8'd255, 100, 70, 1'b1, 1'b1, 1'b0);
        run_phase(4'd1,  8'd128, 170, 95, 1'b1, 1'b0, 1'b0);
        run_phase(4'd8,  8'd255, 80,  50, 1'b1, 1'b0, 1'b0);
        run_phase(4'd0,  8'd32,  20,  50, 1'b1, 1'b0, 1'b0);
        run_phase(4'd3,  8'd0,   20,  50, 1'b1, 1'b0, 1'b0);
        run_phase(4'd8,  8'd1,   80,  50, 1'b1, 1'b0, 1'b0);
        run_phase(4'($urandom_range(1, 8)), 8'($urandom_range(2, 12)), 100,
                  $urandom_range(40, 65), 1'b1, 1'b1, 1'b1);
        run_phase(4'd5,  8'd200, 80,  55, 1'b1, 1'b0, 1'b0);
        // keep the queues from the previous phase: no real register write
        run_phase(4'd5,  8'd200, 60,  40, 1'b0, 1'b0, 1'b0);
        repeat (3)
        begin
            run_phase(4'($urandom_range(0, 15)), 8'($urandom_range(1, 20)), 100,
                      $urandom_range(30, 70), 1'b1, 1'b0, 1'b0);
        end
        run_phase(4'd4,  8'd32,  40,  50, 1'b1, 1'b0, 1'b0);

        wait_drained(SETTLE_CYCLES);
        @(negedge clk);
        $display("Checked %0d accesses: %0d ok, %0d full, %0d empty, %0d inactive queue.",
                 access_count, ok_count, full_count, empty_count, bad_index_count);
        $display("Layouts of 0 to 15 queues and 0 to 255 entries each, %0d register beats.",
                 reg_write_count);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("k_queues_in_one_array regression: pass");
        end
        else
        begin
            $display("k_queues_in_one_array regression: fail");
        end
        $finish;
    end

endmodule
